/* rtl/acbdm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbdm_pkg
// Shared types and constants of the converter to backlight level map.
// ----------------------------------------------------------------------------
package acbdm_pkg;

    // field widths
    localparam int SampleW = 15;
    localparam int RawW    = 16;
    localparam int LevelW  = 8;
    localparam int QuotW   = 8;
    localparam int RemW    = SampleW + LevelW;
    localparam int CntW    = 3;

    // constants of the map
    localparam logic [SampleW-1:0] Deadband  = 15'd50;
    localparam logic [LevelW-1:0]  FullLevel = 8'hff;
    localparam logic [SampleW-1:0] HighReset = 15'd4096;
    localparam logic [CntW-1:0]    LastStep  = 3'd7;

    // register indexes on the configuration port
    localparam logic [1:0] RegRangeLow  = 2'd0;
    localparam logic [1:0] RegRangeHigh = 2'd1;
    localparam logic [1:0] RegInvert    = 2'd2;
    localparam logic [1:0] RegTestMode  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_step;
        logic div_last;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic need_div;
    } status_t;

endpackage

/* rtl/acbdm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbdm_ctrl
// Sequencer: accepts a beat, runs the evaluation and, when the datapath asks
// for it, the divider steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module acbdm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  acbdm_pkg::status_t stat,
    output acbdm_pkg::cmd_t   cmd
);

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StEval = 2'd1;
    localparam logic [1:0] StDiv  = 2'd2;
    localparam logic [1:0] StDone = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [acbdm_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == StIdle);
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            StIdle: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = StEval;
                end
            end
            StEval: begin
                cmd.eval = 1'b1;
                cnt_next = '0;
                if (stat.need_div) begin
                    state_next = StDiv;
                end else begin
                    state_next = StDone;
                end
            end
            StDiv: begin
                cmd.div_step = 1'b1;
                cmd.div_last = (cnt_reg == acbdm_pkg::LastStep);
                cnt_next     = cnt_reg + 1'b1;
                if (cmd.div_last) begin
                    state_next = StDone;
                end
            end
            StDone: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= StIdle;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output slot is free whenever a result is loaded
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a pending beat");

    // a waiting result is not dropped
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> out_valid_reg)
        else $error("pending result lost");

    // evaluation only follows an accepted beat
    a_eval_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == StEval) |-> $past(s_tvalid && s_tready))
        else $error("evaluation without input beat");

    // divider finishes into the hand-off state
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_last |=> (state_reg == StDone))
        else $error("divider end not followed by hand-off");

endmodule

/* rtl/acbdm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acbdm_dp
// Datapath: configuration registers, sample state, deadband test, min / max
// tracking and a restoring divider giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acbdm_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    // input beat
    input  logic [acbdm_pkg::RawW-1:0]     in_raw,
    input  logic                           in_ok,
    // result
    output logic [39:0]                    out_data,
    output logic [2:0]                     out_user,
    // control
    input  acbdm_pkg::cmd_t                cmd,
    output acbdm_pkg::status_t             stat
);

    localparam int SW = acbdm_pkg::SampleW;
    localparam int LW = acbdm_pkg::LevelW;
    localparam int RW = acbdm_pkg::RemW;

    // configuration registers
    logic [SW-1:0] range_low_reg, range_high_reg;
    logic          invert_reg, test_mode_reg;

    // sample state
    logic [SW-1:0] accepted_sample_reg, lowest_reg, highest_reg;
    logic          accepted_valid_reg, extremes_seen_reg;
    logic [LW-1:0] level_reg;
    logic          upd_reg, good_reg;

    // latched input beat
    logic [acbdm_pkg::RawW-1:0] raw_reg;
    logic                       ok_reg;

    // divider
    logic [RW-1:0]              rem_reg;
    logic [RW-1:0]              dsr_reg;
    logic [acbdm_pkg::QuotW-1:0] quot_reg;

    // output payload
    logic [39:0] out_data_reg;
    logic [2:0]  out_user_reg;

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          good;
    logic [SW-1:0] smp, diff, span;
    logic          take, below, above;
    logic [LW-1:0] direct_lvl, quot_final, lvl_new;
    logic [RW-1:0] num, trial;
    logic          ge;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // register read back
    always_comb begin
        case (cfg_idx)
            acbdm_pkg::RegRangeLow:  prdata = {17'd0, range_low_reg};
            acbdm_pkg::RegRangeHigh: prdata = {17'd0, range_high_reg};
            acbdm_pkg::RegInvert:    prdata = {31'd0, invert_reg};
            acbdm_pkg::RegTestMode:  prdata = {31'd0, test_mode_reg};
            default:                 prdata = '0;
        endcase
    end

    // deadband test and direct map
    always_comb begin
        good  = ok_reg && !raw_reg[acbdm_pkg::RawW-1];
        smp   = raw_reg[SW-1:0];
        diff  = (smp > accepted_sample_reg) ? (smp - accepted_sample_reg)
                                            : (accepted_sample_reg - smp);
        take  = good && (!accepted_valid_reg || (diff > acbdm_pkg::Deadband));
        below = (smp < range_low_reg);
        above = (smp > range_high_reg);
        span  = range_high_reg - range_low_reg;
        stat.need_div = take && !below && !above && (span != '0);
        if (above && !below) begin
            direct_lvl = acbdm_pkg::FullLevel;
        end else begin
            direct_lvl = '0;
        end
        // numerator (s - low) * 255
        num = {smp - range_low_reg, {LW{1'b0}}} - {{LW{1'b0}}, smp - range_low_reg};
    end

    // one restoring divider step
    always_comb begin
        ge         = (rem_reg >= dsr_reg);
        trial      = rem_reg - dsr_reg;
        quot_final = {quot_reg[acbdm_pkg::QuotW-2:0], ge};
        lvl_new    = cmd.div_last ? quot_final : direct_lvl;
        if (invert_reg) begin
            lvl_new = acbdm_pkg::FullLevel - lvl_new;
        end
    end

    // configuration and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg       <= '0;
            range_high_reg      <= acbdm_pkg::HighReset;
            invert_reg          <= 1'b0;
            test_mode_reg       <= 1'b0;
            accepted_sample_reg <= '0;
            accepted_valid_reg  <= 1'b0;
            level_reg           <= acbdm_pkg::FullLevel;
            lowest_reg          <= '0;
            highest_reg         <= '0;
            extremes_seen_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    acbdm_pkg::RegRangeLow:  range_low_reg  <= pwdata[SW-1:0];
                    acbdm_pkg::RegRangeHigh: range_high_reg <= pwdata[SW-1:0];
                    acbdm_pkg::RegInvert:    invert_reg     <= pwdata[0];
                    acbdm_pkg::RegTestMode:  test_mode_reg  <= pwdata[0];
                    default: ;
                endcase
            end
            if (cmd.eval) begin
                // min / max tracking
                if (good && test_mode_reg) begin
                    extremes_seen_reg <= 1'b1;
                    if (!extremes_seen_reg || smp < lowest_reg) begin
                        lowest_reg <= smp;
                    end
                    if (!extremes_seen_reg || smp > highest_reg) begin
                        highest_reg <= smp;
                    end
                end
                if (take) begin
                    accepted_sample_reg <= smp;
                    accepted_valid_reg  <= 1'b1;
                    if (!stat.need_div) begin
                        level_reg <= lvl_new;
                    end
                end
            end
            if (cmd.div_last) begin
                level_reg <= lvl_new;
            end
        end
    end

    // input latch, divider and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            raw_reg <= in_raw;
            ok_reg  <= in_ok;
        end
        if (cmd.eval) begin
            upd_reg  <= take;
            good_reg <= good;
            rem_reg  <= num;
            dsr_reg  <= {1'b0, span, {(LW-1){1'b0}}};
            quot_reg <= '0;
        end
        if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= trial;
            end
            dsr_reg  <= {1'b0, dsr_reg[RW-1:1]};
            quot_reg <= quot_final;
        end
        if (cmd.load_out) begin
            out_data_reg <= {2'b00, highest_reg, lowest_reg, level_reg};
            out_user_reg <= {extremes_seen_reg, good_reg, upd_reg};
        end
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule

/* rtl/adc_to_backlight_deadband_map_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_to_backlight_deadband_map_core
// Converter word to backlight level map with deadband and min / max tracking.
// ----------------------------------------------------------------------------
// One result beat per input beat. A beat that is rejected, that stays inside
// the deadband, or whose level needs no division passes from the accept
// through the evaluation state to the hand-off state, where its result is
// loaded. A taken sample inside a nonzero range, bounds included, also runs
// the restoring divider first, one quotient bit per cycle. The next beat is
// accepted in the cycle after the result is loaded into the output register,
// so a waiting result stalls the block only while its slot is full.
// ----------------------------------------------------------------------------
module adc_to_backlight_deadband_map_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // raw_word[15:0]
    input  logic        s_tuser,   // read_ok
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // brightness[7:0], min_seen[22:8], max_seen[37:23]
    output logic [2:0]  m_tuser    // updated[0], sample_good[1], extremes_valid[2]
);

    acbdm_pkg::cmd_t    cmd;
    acbdm_pkg::status_t stat;

    assign pready = 1'b1;

    acbdm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    acbdm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .in_raw   (s_tdata),
        .in_ok    (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
